// ===== rtl/byte_cpu_instruction_step_defines.svh =====
// Assertion macros shared by the byte CPU step block.
`ifndef BYTE_CPU_INSTRUCTION_STEP_DEFINES_SVH
`define BYTE_CPU_INSTRUCTION_STEP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BCIS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BCIS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bcis_pkg.sv =====
// Types, codes and decode function shared by the byte CPU step block.
package bcis_pkg;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] mem_address;
      logic [7:0]  mem_data;
   } bcis_req_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  read_data;
      logic [15:0] prog_counter;
      logic [15:0] stack_ptr;
      logic [7:0]  accum;
      logic [7:0]  flag_byte;
      logic [15:0] pair_bc;
      logic [15:0] pair_de;
      logic [15:0] pair_hl;
      logic        irq_enabled;
   } bcis_rsp_type;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_EXEC  = 2'd2;

   localparam logic [7:0] OP_NOP      = 8'h00;
   localparam logic [7:0] OP_LXI_B    = 8'h01;
   localparam logic [7:0] OP_DCR_B    = 8'h05;
   localparam logic [7:0] OP_MVI_B    = 8'h06;
   localparam logic [7:0] OP_DAD_B    = 8'h09;
   localparam logic [7:0] OP_DCR_C    = 8'h0D;
   localparam logic [7:0] OP_MVI_C    = 8'h0E;
   localparam logic [7:0] OP_RRC      = 8'h0F;
   localparam logic [7:0] OP_LXI_D    = 8'h11;
   localparam logic [7:0] OP_INX_D    = 8'h13;
   localparam logic [7:0] OP_DAD_D    = 8'h19;
   localparam logic [7:0] OP_LDAX_D   = 8'h1A;
   localparam logic [7:0] OP_LXI_H    = 8'h21;
   localparam logic [7:0] OP_INX_H    = 8'h23;
   localparam logic [7:0] OP_MVI_H    = 8'h26;
   localparam logic [7:0] OP_DAD_H    = 8'h29;
   localparam logic [7:0] OP_LXI_SP   = 8'h31;
   localparam logic [7:0] OP_STA      = 8'h32;
   localparam logic [7:0] OP_MVI_M    = 8'h36;
   localparam logic [7:0] OP_LDA      = 8'h3A;
   localparam logic [7:0] OP_MVI_A    = 8'h3E;
   localparam logic [7:0] OP_MOV_D_M  = 8'h56;
   localparam logic [7:0] OP_MOV_E_M  = 8'h5E;
   localparam logic [7:0] OP_MOV_H_M  = 8'h66;
   localparam logic [7:0] OP_MOV_L_A  = 8'h6F;
   localparam logic [7:0] OP_MOV_M_A  = 8'h77;
   localparam logic [7:0] OP_MOV_A_D  = 8'h7A;
   localparam logic [7:0] OP_MOV_A_E  = 8'h7B;
   localparam logic [7:0] OP_MOV_A_H  = 8'h7C;
   localparam logic [7:0] OP_MOV_A_M  = 8'h7E;
   localparam logic [7:0] OP_ANA_A    = 8'hA7;
   localparam logic [7:0] OP_XRA_A    = 8'hAF;
   localparam logic [7:0] OP_POP_B    = 8'hC1;
   localparam logic [7:0] OP_JNZ      = 8'hC2;
   localparam logic [7:0] OP_JMP      = 8'hC3;
   localparam logic [7:0] OP_PUSH_B   = 8'hC5;
   localparam logic [7:0] OP_ADI      = 8'hC6;
   localparam logic [7:0] OP_RET      = 8'hC9;
   localparam logic [7:0] OP_CALL     = 8'hCD;
   localparam logic [7:0] OP_POP_D    = 8'hD1;
   localparam logic [7:0] OP_OUT      = 8'hD3;
   localparam logic [7:0] OP_PUSH_D   = 8'hD5;
   localparam logic [7:0] OP_POP_H    = 8'hE1;
   localparam logic [7:0] OP_PUSH_H   = 8'hE5;
   localparam logic [7:0] OP_ANI      = 8'hE6;
   localparam logic [7:0] OP_XCHG     = 8'hEB;
   localparam logic [7:0] OP_POP_PSW  = 8'hF1;
   localparam logic [7:0] OP_PUSH_PSW = 8'hF5;
   localparam logic [7:0] OP_EI       = 8'hFB;
   localparam logic [7:0] OP_CPI      = 8'hFE;

   typedef enum logic [3:0] {
      AS_REQ, AS_PC0, AS_PC1, AS_PC2, AS_HL, AS_DE, AS_IMM,
      AS_SPM1, AS_SPM2, AS_SP0, AS_SP1
   } bcis_addr_sel_type;

   typedef enum logic [2:0] {
      WS_REQ, WS_A, WS_B1, WS_PUSH_HI, WS_PUSH_LO
   } bcis_wdata_sel_type;

   typedef enum logic [2:0] {
      DST_NONE, DST_OP, DST_B1, DST_B2, DST_LO, DST_HI, DST_RD
   } bcis_dest_type;

   typedef enum logic [2:0] {
      CL_REG, CL_LOAD, CL_STORE, CL_PUSH, CL_POP, CL_BAD
   } bcis_class_type;

   typedef struct packed {
      bcis_class_type     cls;
      bcis_addr_sel_type  addr_sel;
      bcis_wdata_sel_type wdata_sel;
   } bcis_decode_type;

   typedef struct packed {
      logic               mem_issue;
      logic               mem_we;
      bcis_addr_sel_type  addr_sel;
      bcis_wdata_sel_type wdata_sel;
      bcis_dest_type      dest;
      logic               apply;
      logic               accept;
      logic               clr_step;
   } bcis_cmd_type;

   typedef struct packed {
      logic            halted;
      logic            clr_last;
      bcis_decode_type dec;
   } bcis_status_type;

   function automatic bcis_decode_type bcis_decode(input logic [7:0] op);
      bcis_decode_type d;
      d.cls       = CL_BAD;
      d.addr_sel  = AS_HL;
      d.wdata_sel = WS_A;
      unique case (op)
         OP_NOP, OP_LXI_B, OP_DCR_B, OP_MVI_B, OP_DAD_B, OP_DCR_C, OP_MVI_C,
         OP_RRC, OP_LXI_D, OP_INX_D, OP_DAD_D, OP_LXI_H, OP_INX_H, OP_MVI_H,
         OP_DAD_H, OP_LXI_SP, OP_MVI_A, OP_MOV_L_A, OP_MOV_A_D, OP_MOV_A_E,
         OP_MOV_A_H, OP_ANA_A, OP_XRA_A, OP_JNZ, OP_JMP, OP_ADI, OP_OUT,
         OP_ANI, OP_XCHG, OP_EI, OP_CPI:
            d.cls = CL_REG;
         OP_LDAX_D: begin
            d.cls      = CL_LOAD;
            d.addr_sel = AS_DE;
         end
         OP_LDA: begin
            d.cls      = CL_LOAD;
            d.addr_sel = AS_IMM;
         end
         OP_MOV_D_M, OP_MOV_E_M, OP_MOV_H_M, OP_MOV_A_M:
            d.cls = CL_LOAD;
         OP_STA: begin
            d.cls      = CL_STORE;
            d.addr_sel = AS_IMM;
         end
         OP_MVI_M: begin
            d.cls       = CL_STORE;
            d.wdata_sel = WS_B1;
         end
         OP_MOV_M_A:
            d.cls = CL_STORE;
         OP_PUSH_B, OP_PUSH_D, OP_PUSH_H, OP_PUSH_PSW, OP_CALL: begin
            d.cls       = CL_PUSH;
            d.addr_sel  = AS_SPM1;
            d.wdata_sel = WS_PUSH_HI;
         end
         OP_POP_B, OP_POP_D, OP_POP_H, OP_POP_PSW, OP_RET: begin
            d.cls      = CL_POP;
            d.addr_sel = AS_SP0;
         end
         default:
            d.cls = CL_BAD;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/bcis_ram.sv =====
// Generic single-port RAM with registered read data.
module bcis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bcis_dp.sv =====
// Datapath: register file, flags, address reduction, memory and execute logic.
module bcis_dp #(
   parameter int MEM_DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bcis_pkg::bcis_req_type   req,
   input  bcis_pkg::bcis_cmd_type   cmd,
   output bcis_pkg::bcis_status_type st,
   output bcis_pkg::bcis_rsp_type   rsp
);

   localparam int AW   = $clog2(MEM_DEPTH);
   localparam int QMAX = 65535 / MEM_DEPTH;
   localparam int QW   = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
   localparam longint unsigned RECIP_L = ((64'd1 << 32) + MEM_DEPTH - 1) / MEM_DEPTH;
   localparam logic [24:0] RECIP = 25'(RECIP_L);

   // architectural state
   logic [7:0]  b_ff, c_ff, d_ff, e_ff, h_ff, l_ff, a_ff;
   logic [7:0]  b_in, c_in, d_in, e_in, h_in, l_in, a_in;
   logic [15:0] sp_ff, sp_in, pc_ff, pc_in;
   logic        fcy_ff, fp_ff, fac_ff, fz_ff, fs_ff;
   logic        fcy_in, fp_in, fac_in, fz_in, fs_in;
   logic        ie_ff, ie_in, halt_ff, halt_in;

   // fetched bytes and memory operands
   logic [7:0]  op_ff, b1_ff, b2_ff, lo_ff, hi_ff, rd_ff;

   // address pipeline
   logic [15:0] raw_w, raw_ff;
   logic [40:0] prod_w;
   logic [QW-1:0] q_ff;
   logic [16:0] qd_w, rem_w;
   logic        s1_vld_ff, s1_we_ff;
   logic [7:0]  s1_wd_ff, wd_w;
   bcis_pkg::bcis_dest_type s1_dst_ff, s2_dst_ff, s2_dst_in;

   logic [AW-1:0] clr_cnt_ff;
   logic [AW-1:0] ram_addr;
   logic          ram_we;
   logic [7:0]    ram_wd, ram_rd;

   logic [15:0] hl_w, de_w, bc_w, imm_w, ret_w;
   logic [7:0]  push_hi_w, push_lo_w, psw_w;

   function automatic logic [2:0] zsp_f(input logic [7:0] v);
      return {v[7], (v == 8'd0), ~^v};
   endfunction

   assign hl_w  = {h_ff, l_ff};
   assign de_w  = {d_ff, e_ff};
   assign bc_w  = {b_ff, c_ff};
   assign imm_w = {b2_ff, b1_ff};
   assign ret_w = pc_ff + 16'd3;
   assign psw_w = {fs_ff, fz_ff, 1'b0, fac_ff, 1'b0, fp_ff, 1'b1, fcy_ff};

   always_comb begin
      push_hi_w = a_ff;
      push_lo_w = psw_w;
      unique case (op_ff)
         bcis_pkg::OP_PUSH_B: begin
            push_hi_w = b_ff;
            push_lo_w = c_ff;
         end
         bcis_pkg::OP_PUSH_D: begin
            push_hi_w = d_ff;
            push_lo_w = e_ff;
         end
         bcis_pkg::OP_PUSH_H: begin
            push_hi_w = h_ff;
            push_lo_w = l_ff;
         end
         bcis_pkg::OP_CALL: begin
            push_hi_w = ret_w[15:8];
            push_lo_w = ret_w[7:0];
         end
         default: begin
            push_hi_w = a_ff;
            push_lo_w = psw_w;
         end
      endcase
   end

   // raw address and write data select
   always_comb begin
      unique case (cmd.addr_sel)
         bcis_pkg::AS_REQ:  raw_w = req.mem_address;
         bcis_pkg::AS_PC0:  raw_w = pc_ff;
         bcis_pkg::AS_PC1:  raw_w = pc_ff + 16'd1;
         bcis_pkg::AS_PC2:  raw_w = pc_ff + 16'd2;
         bcis_pkg::AS_HL:   raw_w = hl_w;
         bcis_pkg::AS_DE:   raw_w = de_w;
         bcis_pkg::AS_IMM:  raw_w = imm_w;
         bcis_pkg::AS_SPM1: raw_w = sp_ff - 16'd1;
         bcis_pkg::AS_SPM2: raw_w = sp_ff - 16'd2;
         bcis_pkg::AS_SP0:  raw_w = sp_ff;
         bcis_pkg::AS_SP1:  raw_w = sp_ff + 16'd1;
         default:           raw_w = pc_ff;
      endcase
      unique case (cmd.wdata_sel)
         bcis_pkg::WS_REQ:     wd_w = req.mem_data;
         bcis_pkg::WS_A:       wd_w = a_ff;
         bcis_pkg::WS_B1:      wd_w = b1_ff;
         bcis_pkg::WS_PUSH_HI: wd_w = push_hi_w;
         bcis_pkg::WS_PUSH_LO: wd_w = push_lo_w;
         default:              wd_w = a_ff;
      endcase
   end

   // quotient by reciprocal, exact for 16-bit addresses
   assign prod_w = 41'(raw_w) * 41'(RECIP);
   assign qd_w   = 17'(q_ff) * 17'(MEM_DEPTH);
   assign rem_w  = 17'(raw_ff) - qd_w;

   always_ff @(posedge clock) begin
      raw_ff   <= raw_w;
      q_ff     <= QW'(prod_w[40:32]);
      s1_we_ff <= cmd.mem_we;
      s1_wd_ff <= wd_w;
      s1_dst_ff <= cmd.dest;
   end

   assign s2_dst_in = (s1_vld_ff && !s1_we_ff) ? s1_dst_ff : bcis_pkg::DST_NONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_dst_ff  <= bcis_pkg::DST_NONE;
         clr_cnt_ff <= '0;
      end else begin
         s1_vld_ff <= cmd.mem_issue;
         s2_dst_ff <= s2_dst_in;
         if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
      end
   end

   always_comb begin
      if (cmd.clr_step) begin
         ram_addr = clr_cnt_ff;
         ram_we   = 1'b1;
         ram_wd   = 8'd0;
      end else begin
         ram_addr = rem_w[AW-1:0];
         ram_we   = s1_vld_ff && s1_we_ff;
         ram_wd   = s1_wd_ff;
      end
   end

   bcis_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wd),
      .rdata (ram_rd)
   );

   // capture returned bytes
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_ff <= 8'd0;
      end
      unique case (s2_dst_ff)
         bcis_pkg::DST_OP: op_ff <= ram_rd;
         bcis_pkg::DST_B1: b1_ff <= ram_rd;
         bcis_pkg::DST_B2: b2_ff <= ram_rd;
         bcis_pkg::DST_LO: lo_ff <= ram_rd;
         bcis_pkg::DST_HI: hi_ff <= ram_rd;
         bcis_pkg::DST_RD: rd_ff <= ram_rd;
         default: ;
      endcase
   end

   // instruction effects
   always_comb begin
      logic [16:0] sum17;
      logic [8:0]  sum9;
      logic [7:0]  res8;
      logic [2:0]  f3;
      b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      h_in = h_ff; l_in = l_ff; a_in = a_ff;
      sp_in = sp_ff; pc_in = pc_ff;
      fcy_in = fcy_ff; fp_in = fp_ff; fac_in = fac_ff; fz_in = fz_ff; fs_in = fs_ff;
      ie_in = ie_ff; halt_in = halt_ff;
      sum17 = '0;
      sum9  = '0;
      res8  = '0;
      f3    = '0;
      if (cmd.apply) begin
         unique case (op_ff)
            bcis_pkg::OP_NOP: pc_in = pc_ff + 16'd1;
            bcis_pkg::OP_LXI_B: begin
               {b_in, c_in} = imm_w;
               pc_in = pc_ff + 16'd3;
            end
            bcis_pkg::OP_LXI_D: begin
               {d_in, e_in} = imm_w;
               pc_in = pc_ff + 16'd3;
            end
            bcis_pkg::OP_LXI_H: begin
               {h_in, l_in} = imm_w;
               pc_in = pc_ff + 16'd3;
            end
            bcis_pkg::OP_LXI_SP: begin
               sp_in = imm_w;
               pc_in = pc_ff + 16'd3;
            end
            bcis_pkg::OP_DCR_B, bcis_pkg::OP_DCR_C: begin
               res8 = (op_ff == bcis_pkg::OP_DCR_B) ? b_ff : c_ff;
               fac_in = (res8[3:0] == 4'd0);
               res8 = res8 - 8'd1;
               f3 = zsp_f(res8);
               {fs_in, fz_in, fp_in} = f3;
               if (op_ff == bcis_pkg::OP_DCR_B) b_in = res8;
               else c_in = res8;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_MVI_B: begin
               b_in = b1_ff;
               pc_in = pc_ff + 16'd2;
            end
            bcis_pkg::OP_MVI_C: begin
               c_in = b1_ff;
               pc_in = pc_ff + 16'd2;
            end
            bcis_pkg::OP_MVI_H: begin
               h_in = b1_ff;
               pc_in = pc_ff + 16'd2;
            end
            bcis_pkg::OP_MVI_A: begin
               a_in = b1_ff;
               pc_in = pc_ff + 16'd2;
            end
            bcis_pkg::OP_MVI_M, bcis_pkg::OP_OUT: pc_in = pc_ff + 16'd2;
            bcis_pkg::OP_STA: pc_in = pc_ff + 16'd3;
            bcis_pkg::OP_MOV_M_A: pc_in = pc_ff + 16'd1;
            bcis_pkg::OP_DAD_B, bcis_pkg::OP_DAD_D, bcis_pkg::OP_DAD_H: begin
               if (op_ff == bcis_pkg::OP_DAD_B) sum17 = 17'(hl_w) + 17'(bc_w);
               else if (op_ff == bcis_pkg::OP_DAD_D) sum17 = 17'(hl_w) + 17'(de_w);
               else sum17 = 17'(hl_w) + 17'(hl_w);
               fcy_in = sum17[16];
               {h_in, l_in} = sum17[15:0];
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_RRC: begin
               a_in = {a_ff[0], a_ff[7:1]};
               fcy_in = a_ff[0];
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_INX_D: begin
               {d_in, e_in} = de_w + 16'd1;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_INX_H: begin
               {h_in, l_in} = hl_w + 16'd1;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_LDAX_D, bcis_pkg::OP_MOV_A_M: begin
               a_in = lo_ff;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_LDA: begin
               a_in = lo_ff;
               pc_in = pc_ff + 16'd3;
            end
            bcis_pkg::OP_MOV_D_M: begin
               d_in = lo_ff;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_MOV_E_M: begin
               e_in = lo_ff;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_MOV_H_M: begin
               h_in = lo_ff;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_MOV_L_A: begin
               l_in = a_ff;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_MOV_A_D: begin
               a_in = d_ff;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_MOV_A_E: begin
               a_in = e_ff;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_MOV_A_H: begin
               a_in = h_ff;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_ANA_A: begin
               f3 = zsp_f(a_ff);
               {fs_in, fz_in, fp_in} = f3;
               fac_in = a_ff[3];
               fcy_in = 1'b0;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_XRA_A: begin
               a_in = 8'd0;
               {fs_in, fz_in, fp_in} = 3'b011;
               fcy_in = 1'b0;
               fac_in = 1'b0;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_ANI: begin
               res8 = a_ff & b1_ff;
               a_in = res8;
               f3 = zsp_f(res8);
               {fs_in, fz_in, fp_in} = f3;
               fcy_in = 1'b0;
               fac_in = 1'b0;
               pc_in = pc_ff + 16'd2;
            end
            bcis_pkg::OP_ADI: begin
               sum9 = 9'(a_ff) + 9'(b1_ff);
               a_in = sum9[7:0];
               f3 = zsp_f(sum9[7:0]);
               {fs_in, fz_in, fp_in} = f3;
               fcy_in = sum9[8];
               sum9 = 9'(a_ff[3:0]) + 9'(b1_ff[3:0]);
               fac_in = sum9[4];
               pc_in = pc_ff + 16'd2;
            end
            bcis_pkg::OP_CPI: begin
               res8 = a_ff - b1_ff;
               f3 = zsp_f(res8);
               {fs_in, fz_in, fp_in} = f3;
               fcy_in = (a_ff < b1_ff);
               fac_in = (a_ff[3:0] < b1_ff[3:0]);
               pc_in = pc_ff + 16'd2;
            end
            bcis_pkg::OP_JNZ: pc_in = fz_ff ? (pc_ff + 16'd3) : imm_w;
            bcis_pkg::OP_JMP: pc_in = imm_w;
            bcis_pkg::OP_CALL: begin
               sp_in = sp_ff - 16'd2;
               pc_in = imm_w;
            end
            bcis_pkg::OP_PUSH_B, bcis_pkg::OP_PUSH_D, bcis_pkg::OP_PUSH_H,
            bcis_pkg::OP_PUSH_PSW: begin
               sp_in = sp_ff - 16'd2;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_POP_B: begin
               {b_in, c_in} = {hi_ff, lo_ff};
               sp_in = sp_ff + 16'd2;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_POP_D: begin
               {d_in, e_in} = {hi_ff, lo_ff};
               sp_in = sp_ff + 16'd2;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_POP_H: begin
               {h_in, l_in} = {hi_ff, lo_ff};
               sp_in = sp_ff + 16'd2;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_POP_PSW: begin
               fs_in  = lo_ff[7];
               fz_in  = lo_ff[6];
               fac_in = lo_ff[4];
               fp_in  = lo_ff[2];
               fcy_in = lo_ff[0];
               a_in   = hi_ff;
               sp_in  = sp_ff + 16'd2;
               pc_in  = pc_ff + 16'd1;
            end
            bcis_pkg::OP_RET: begin
               pc_in = {hi_ff, lo_ff};
               sp_in = sp_ff + 16'd2;
            end
            bcis_pkg::OP_XCHG: begin
               {h_in, l_in} = de_w;
               {d_in, e_in} = hl_w;
               pc_in = pc_ff + 16'd1;
            end
            bcis_pkg::OP_EI: begin
               ie_in = 1'b1;
               pc_in = pc_ff + 16'd1;
            end
            default: halt_in = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= '0; c_ff <= '0; d_ff <= '0; e_ff <= '0;
         h_ff <= '0; l_ff <= '0; a_ff <= '0;
         sp_ff <= '0; pc_ff <= '0;
         fcy_ff <= 1'b0; fp_ff <= 1'b0; fac_ff <= 1'b0; fz_ff <= 1'b0; fs_ff <= 1'b0;
         ie_ff <= 1'b0; halt_ff <= 1'b0;
      end else begin
         b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
         h_ff <= h_in; l_ff <= l_in; a_ff <= a_in;
         sp_ff <= sp_in; pc_ff <= pc_in;
         fcy_ff <= fcy_in; fp_ff <= fp_in; fac_ff <= fac_in; fz_ff <= fz_in; fs_ff <= fs_in;
         ie_ff <= ie_in; halt_ff <= halt_in;
      end
   end

   assign st.halted   = halt_ff;
   assign st.clr_last = (clr_cnt_ff == AW'(MEM_DEPTH - 1));
   assign st.dec      = bcis_pkg::bcis_decode(op_ff);

   assign rsp.status       = halt_ff;
   assign rsp.read_data    = rd_ff;
   assign rsp.prog_counter = pc_ff;
   assign rsp.stack_ptr    = sp_ff;
   assign rsp.accum        = a_ff;
   assign rsp.flag_byte    = psw_w;
   assign rsp.pair_bc      = bc_w;
   assign rsp.pair_de      = de_w;
   assign rsp.pair_hl      = hl_w;
   assign rsp.irq_enabled  = ie_ff;

endmodule

// ===== rtl/bcis_ctrl.sv =====
// Controller: sequences memory clear, fetch, operand and stack transfers.
`include "byte_cpu_instruction_step_defines.svh"

module bcis_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                req_type,
   input  bcis_pkg::bcis_status_type st,
   output logic                      busy,
   output logic                      done,
   output bcis_pkg::bcis_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_F1, ST_F2, ST_X1, ST_X2, ST_EXEC,
      ST_SECOND, ST_W1, ST_W2, ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      done_ff, done_in;
   logic      exec_ff, exec_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in      = state_ff;
      done_in       = 1'b0;
      exec_in       = exec_ff;
      cmd.mem_issue = 1'b0;
      cmd.mem_we    = 1'b0;
      cmd.addr_sel  = bcis_pkg::AS_REQ;
      cmd.wdata_sel = bcis_pkg::WS_REQ;
      cmd.dest      = bcis_pkg::DST_NONE;
      cmd.apply     = 1'b0;
      cmd.accept    = accept;
      cmd.clr_step  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  bcis_pkg::REQ_WRITE: begin
                     cmd.mem_issue = 1'b1;
                     cmd.mem_we    = 1'b1;
                     done_in       = 1'b1;
                  end
                  bcis_pkg::REQ_READ: begin
                     cmd.mem_issue = 1'b1;
                     cmd.dest      = bcis_pkg::DST_RD;
                     exec_in       = 1'b0;
                     state_in      = ST_W1;
                  end
                  bcis_pkg::REQ_EXEC: begin
                     if (st.halted) begin
                        done_in = 1'b1;
                     end else begin
                        cmd.mem_issue = 1'b1;
                        cmd.addr_sel  = bcis_pkg::AS_PC0;
                        cmd.dest      = bcis_pkg::DST_OP;
                        exec_in       = 1'b1;
                        state_in      = ST_F1;
                     end
                  end
                  default: done_in = 1'b1;
               endcase
            end
         end
         ST_F1: begin
            cmd.mem_issue = 1'b1;
            cmd.addr_sel  = bcis_pkg::AS_PC1;
            cmd.dest      = bcis_pkg::DST_B1;
            state_in      = ST_F2;
         end
         ST_F2: begin
            cmd.mem_issue = 1'b1;
            cmd.addr_sel  = bcis_pkg::AS_PC2;
            cmd.dest      = bcis_pkg::DST_B2;
            state_in      = ST_X1;
         end
         ST_X1: state_in = ST_X2;
         ST_X2: state_in = ST_EXEC;
         ST_EXEC: begin
            unique case (st.dec.cls)
               bcis_pkg::CL_LOAD: begin
                  cmd.mem_issue = 1'b1;
                  cmd.addr_sel  = st.dec.addr_sel;
                  cmd.dest      = bcis_pkg::DST_LO;
                  state_in      = ST_W1;
               end
               bcis_pkg::CL_STORE: begin
                  cmd.mem_issue = 1'b1;
                  cmd.mem_we    = 1'b1;
                  cmd.addr_sel  = st.dec.addr_sel;
                  cmd.wdata_sel = st.dec.wdata_sel;
                  cmd.apply     = 1'b1;
                  done_in       = 1'b1;
                  state_in      = ST_IDLE;
               end
               bcis_pkg::CL_PUSH: begin
                  cmd.mem_issue = 1'b1;
                  cmd.mem_we    = 1'b1;
                  cmd.addr_sel  = bcis_pkg::AS_SPM1;
                  cmd.wdata_sel = bcis_pkg::WS_PUSH_HI;
                  state_in      = ST_SECOND;
               end
               bcis_pkg::CL_POP: begin
                  cmd.mem_issue = 1'b1;
                  cmd.addr_sel  = bcis_pkg::AS_SP0;
                  cmd.dest      = bcis_pkg::DST_LO;
                  state_in      = ST_SECOND;
               end
               default: begin
                  cmd.apply = 1'b1;
                  done_in   = 1'b1;
                  state_in  = ST_IDLE;
               end
            endcase
         end
         ST_SECOND: begin
            cmd.mem_issue = 1'b1;
            if (st.dec.cls == bcis_pkg::CL_PUSH) begin
               cmd.mem_we    = 1'b1;
               cmd.addr_sel  = bcis_pkg::AS_SPM2;
               cmd.wdata_sel = bcis_pkg::WS_PUSH_LO;
               cmd.apply     = 1'b1;
               done_in       = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.addr_sel = bcis_pkg::AS_SP1;
               cmd.dest     = bcis_pkg::DST_HI;
               state_in     = ST_W1;
            end
         end
         ST_W1: state_in = ST_W2;
         ST_W2: begin
            if (exec_ff) begin
               state_in = ST_FIN;
            end else begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FIN: begin
            cmd.apply = 1'b1;
            done_in   = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         done_ff  <= 1'b0;
         exec_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         exec_ff  <= exec_in;
      end
   end

   assign done = done_ff;

   `BCIS_ASSERT_NXT(a_accept_progress, accept, busy || done_ff, "accepted request made no progress")
   `BCIS_ASSERT_IMP(a_issue_owned, cmd.mem_issue, (state_ff != ST_IDLE) || accept, "memory issue while idle")
   `BCIS_ASSERT_NXT(a_halt_sticky, st.halted, st.halted, "halt flag dropped")
   `BCIS_ASSERT_IMP(a_clear_complete, (state_ff == ST_IDLE) && $past(state_ff == ST_CLEAR), $past(st.clr_last), "clear pass left early")

endmodule

// ===== rtl/byte_cpu_instruction_step.sv =====
// Request flow (accept to rsp_strobe): write, unknown type or halted execute wait on no read;
// read waits on one; execute fetches, then applies, stores, pushes (push, call), loads or pops.
// Execute: 3 fetch transfers, registered address reduction, 1 memory port.
// Throughput: one request at a time; next start may land in the strobe cycle.
// Reset: synchronous, clears the architectural registers, then zeroes MEM_DEPTH bytes,
// one byte per cycle, with busy high until the sweep ends.
// Results cannot be held off: each stands one cycle under rsp_strobe.
module byte_cpu_instruction_step #(
   parameter int MEM_DEPTH = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  bcis_pkg::bcis_req_type req_payload,
   output logic                   rsp_strobe,
   output bcis_pkg::bcis_rsp_type rsp_payload
);

   // command and status bundles between sequencer and datapath
   bcis_pkg::bcis_cmd_type    cmd;
   bcis_pkg::bcis_status_type st;

   // Sequencer: owns the clear sweep, instruction fetch, operand and stack
   // transfers, and the one-cycle result strobe.
   bcis_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_payload.req_type),
      .st       (st),
      .busy     (busy),
      .done     (rsp_strobe),
      .cmd      (cmd)
   );

   // Datapath: registers, flags, address reduction modulo MEM_DEPTH,
   // byte memory and the per-opcode execute logic.
   bcis_dp #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_payload),
      .cmd   (cmd),
      .st    (st),
      .rsp   (rsp_payload)
   );

endmodule
